FILE: rtl/bsd_pkg.sv
// Shared constants, codes and types of the bounded sorted deque.
`default_nettype none
package bsd_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int VALUE_BITS = 32;

	localparam int OP_W   = 3;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_SORTED = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_RM_FRONT   = 3'd3;
	localparam logic [OP_W-1:0] OP_RM_VALUE   = 3'd4;
	localparam logic [OP_W-1:0] OP_RM_BACK    = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
	localparam logic [OP_W-1:0] OP_DUMP       = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic                         we;
		logic [ADDR_W-1:0]            waddr;
		logic signed [VALUE_BITS-1:0] wdata;
		logic                         re;
		logic [ADDR_W-1:0]            raddr;
	} mem_req_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_res_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRD  = 9'b000000010,
		S_SEV  = 9'b000000100,
		S_UP   = 9'b000001000,
		S_UPW  = 9'b000010000,
		S_DN   = 9'b000100000,
		S_DNW  = 9'b001000000,
		S_DOUT = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/bsd_if.sv
// Request and response channel interfaces of the bounded sorted deque.
`default_nettype none
interface bsd_req_if;
	import bsd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

interface bsd_rsp_if;
	import bsd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] element;
	logic [OCC_W-1:0]         occupancy;
	logic                     last;

	modport source (output valid, status, element, occupancy, last, input ready);
	modport sink (input valid, status, element, occupancy, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/bounded_sorted_deque_core.sv
// Top level of the bounded sorted deque: request sequencer, storage and compare unit.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, value
//   rsp      out  valid/ready   status, element, occupancy, last
//
// Each request is taken only when the sequencer is idle and then runs alone.
// Every step of a search or shift is one storage read followed by one write or
// compare on the single storage port pair.
// Insert and remove hold the sequencer while they compare and move words; clear
// and full or empty cases go straight to the response. A dump reads and emits
// each stored word in turn, one response per word.
// Reset empties the list at once. A stalled response holds its register and
// pauses the sequencer before it loads the next response.
`default_nettype none
module bounded_sorted_deque_core (
	input  wire logic clk,
	input  wire logic arst_n,
	bsd_req_if.sink   req,
	bsd_rsp_if.source rsp
);
	import bsd_pkg::*;

	state_t                       state_q, state_d;
	logic [OP_W-1:0]              op_q, op_d;
	logic signed [VALUE_BITS-1:0] val_q, val_d;
	logic [CNT_W-1:0]             cnt_q, cnt_d;
	logic [CNT_W-1:0]             idx_q, idx_d;
	logic [CNT_W-1:0]             pos_q, pos_d;
	logic [STAT_W-1:0]            stat_q, stat_d;

	logic                         ov_q;
	logic [STAT_W-1:0]            ost_q, ost_d;
	logic signed [WORD_W-1:0]     oel_q, oel_d;
	logic [OCC_W-1:0]             ooc_q, ooc_d;
	logic                         olast_q, olast_d;
	logic                         out_load;
	logic                         out_free;

	mem_req_t                     mreq;
	logic signed [VALUE_BITS-1:0] rdata;
	cmp_res_t                     cmp;
	logic signed [VALUE_BITS-1:0] val_ext;
	logic [CNT_W-1:0]             idx_p1;
	logic [CNT_W-1:0]             idx_m1;
	logic [CNT_W-1:0]             cnt_m1;

	bsd_store u_store (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	bsd_cmp u_cmp (
		.key   (val_q),
		.entry (rdata),
		.res   (cmp)
	);

	assign val_ext  = VALUE_BITS'(req.value);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		stat_d    = stat_q;
		out_load  = 1'b0;
		ost_d     = ST_OK;
		oel_d     = '0;
		ooc_d     = OCC_W'(cnt_q);
		olast_d   = 1'b1;
		mreq      = '0;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d   = req.op;
					val_d  = val_ext;
					idx_d  = '0;
					pos_d  = '0;
					stat_d = ST_OK;
					case (req.op)
						OP_INS_FRONT, OP_INS_SORTED, OP_INS_BACK: begin
							if (cnt_q == CNT_W'(LIST_DEPTH)) begin
								stat_d  = ST_FULL;
								state_d = S_EMIT;
							end else if (req.op == OP_INS_FRONT) begin
								idx_d   = cnt_q;
								state_d = S_UP;
							end else if (req.op == OP_INS_BACK) begin
								idx_d   = cnt_q;
								pos_d   = cnt_q;
								state_d = S_UP;
							end else if (cnt_q == '0) begin
								state_d = S_UP;
							end else begin
								state_d = S_SRD;
							end
						end
						OP_RM_FRONT, OP_RM_VALUE, OP_RM_BACK: begin
							if (cnt_q == '0) begin
								stat_d  = ST_EMPTY;
								state_d = S_EMIT;
							end else if (req.op == OP_RM_FRONT) begin
								state_d = S_DN;
							end else if (req.op == OP_RM_BACK) begin
								idx_d   = cnt_m1;
								state_d = S_DN;
							end else begin
								state_d = S_SRD;
							end
						end
						OP_CLEAR: begin
							stat_d  = (cnt_q == '0) ? ST_EMPTY : ST_OK;
							cnt_d   = '0;
							state_d = S_EMIT;
						end
						default: begin
							if (cnt_q == '0) begin
								stat_d  = ST_EMPTY;
								state_d = S_EMIT;
							end else begin
								state_d = S_SRD;
							end
						end
					endcase
				end
			end
			S_SRD: begin
				mreq.re    = 1'b1;
				mreq.raddr = idx_q[ADDR_W-1:0];
				state_d    = (op_q == OP_DUMP) ? S_DOUT : S_SEV;
			end
			S_SEV: begin
				if (op_q == OP_RM_VALUE) begin
					if (cmp.eq) begin
						state_d = S_DN;
					end else if (idx_p1 == cnt_q) begin
						stat_d  = ST_NOT_FOUND;
						state_d = S_EMIT;
					end else begin
						idx_d   = idx_p1;
						state_d = S_SRD;
					end
				end else if (cmp.gt) begin
					if (idx_p1 == cnt_q) begin
						pos_d   = cnt_q;
						idx_d   = cnt_q;
						state_d = S_UP;
					end else begin
						idx_d   = idx_p1;
						state_d = S_SRD;
					end
				end else begin
					pos_d   = idx_q;
					idx_d   = cnt_q;
					state_d = S_UP;
				end
			end
			S_UP: begin
				if (idx_q == pos_q) begin
					mreq.we    = 1'b1;
					mreq.waddr = pos_q[ADDR_W-1:0];
					mreq.wdata = val_q;
					cnt_d      = cnt_q + CNT_W'(1);
					state_d    = S_EMIT;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = idx_m1[ADDR_W-1:0];
					state_d    = S_UPW;
				end
			end
			S_UPW: begin
				mreq.we    = 1'b1;
				mreq.waddr = idx_q[ADDR_W-1:0];
				mreq.wdata = rdata;
				idx_d      = idx_m1;
				state_d    = S_UP;
			end
			S_DN: begin
				if (idx_p1 >= cnt_q) begin
					cnt_d   = cnt_m1;
					state_d = S_EMIT;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = idx_p1[ADDR_W-1:0];
					state_d    = S_DNW;
				end
			end
			S_DNW: begin
				mreq.we    = 1'b1;
				mreq.waddr = idx_q[ADDR_W-1:0];
				mreq.wdata = rdata;
				idx_d      = idx_p1;
				state_d    = S_DN;
			end
			S_DOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					ost_d    = ST_OK;
					oel_d    = WORD_W'(rdata);
					olast_d  = (idx_p1 == cnt_q);
					if (idx_p1 == cnt_q) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_p1;
						state_d = S_SRD;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					ost_d    = stat_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		val_q  <= val_d;
		idx_q  <= idx_d;
		pos_q  <= pos_d;
		stat_q <= stat_d;
		if (out_load) begin
			ost_q   <= ost_d;
			oel_q   <= oel_d;
			ooc_q   <= ooc_d;
			olast_q <= olast_d;
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.status    = ost_q;
	assign rsp.element   = oel_q;
	assign rsp.occupancy = ooc_q;
	assign rsp.last      = olast_q;
endmodule
`default_nettype wire

FILE: rtl/bsd_store.sv
// Entry storage: one write port and one read port with registered read data.
`default_nettype none
module bsd_store (
	input  wire logic                                  clk,
	input  wire bsd_pkg::mem_req_t                     req,
	output logic signed [bsd_pkg::VALUE_BITS-1:0]      rdata
);
	import bsd_pkg::*;

	logic signed [VALUE_BITS-1:0] mem [LIST_DEPTH];
	logic signed [VALUE_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rdata = rd_q;
endmodule
`default_nettype wire

FILE: rtl/bsd_cmp.sv
// Shared compare unit: signed greater-than and equality of the key against an entry.
`default_nettype none
module bsd_cmp (
	input  wire logic signed [bsd_pkg::VALUE_BITS-1:0] key,
	input  wire logic signed [bsd_pkg::VALUE_BITS-1:0] entry,
	output bsd_pkg::cmp_res_t                          res
);
	import bsd_pkg::*;

	always_comb begin
		res.gt = (key > entry);
		res.eq = (key == entry);
	end
endmodule
`default_nettype wire

FILE: rtl/bsd_checker.sv
// Port-level checker of the bounded sorted deque and its bind to the top level.
`default_nettype none
module bsd_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               req_valid,
	input wire logic                               req_ready,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic [bsd_pkg::STAT_W-1:0]         rsp_status,
	input wire logic signed [bsd_pkg::WORD_W-1:0]  rsp_element,
	input wire logic [bsd_pkg::OCC_W-1:0]          rsp_occupancy,
	input wire logic                               rsp_last
);
	import bsd_pkg::*;

	// A waiting response keeps its whole word until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_element) && $stable(rsp_occupancy) && $stable(rsp_last))
		else $error("response changed while stalled");

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OCC_W'(LIST_DEPTH))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0 && rsp_element == '0
			&& rsp_last)
		else $error("empty status on a non-empty list");

	// Only dump words come without last, and they always report success.
	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_occupancy != '0)
		else $error("bad intermediate dump word");
endmodule

bind bounded_sorted_deque_core bsd_checker u_bsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_element   (rsp.element),
	.rsp_occupancy (rsp.occupancy),
	.rsp_last      (rsp.last)
);
`default_nettype wire
